// File: design/abg_pkg.sv
// Shared constants, codes and handshake structs for the alpha-beta-gamma tracking filter.
// Used by abg_serial_mul, alpha_beta_gamma_tracking_filter_top and the testbench.
package abg_pkg;

	localparam int SAMPLE_W  = 32;                  // measurement and result width
	localparam int STATE_W   = 48;                  // estimate width, 16 fraction bits
	localparam int COEF_W    = 32;                  // gain and period register width
	localparam int DIGIT_W   = 4;                   // multiplier digit per cycle
	localparam int MUL_STEPS = COEF_W / DIGIT_W;
	localparam int STEP_W    = $clog2(MUL_STEPS);
	localparam int PROD_W    = STATE_W + COEF_W;    // full product width
	localparam int PP_W      = STATE_W + DIGIT_W;   // partial product width
	localparam int TIME_FRAC = 16;
	localparam int GAIN_FRAC = 30;
	localparam int SHF_W     = PROD_W - TIME_FRAC;  // widest shifted product

	localparam int CFG_IDX_W = 3;
	localparam int OUT_W     = 3 * SAMPLE_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD = 3'd4;

	// product scaling codes
	localparam logic [1:0] SH_TIME = 2'd0;          // >> TIME_FRAC
	localparam logic [1:0] SH_HALF = 2'd1;          // >> TIME_FRAC + 1
	localparam logic [1:0] SH_GAIN = 2'd2;          // >> GAIN_FRAC

	typedef logic signed [STATE_W-1:0] state_t;

	typedef struct packed {
		logic              start;
		state_t            x;
		logic [COEF_W-1:0] m;
		logic [1:0]        sh;
	} mul_req_t;

	typedef struct packed {
		logic   done;
		state_t res;
	} mul_rsp_t;

endpackage

// File: design/abg_serial_mul.sv
// Digit-serial signed-by-unsigned multiplier with rounded scaling and saturation.
// Depends on abg_pkg.
module abg_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  abg_pkg::mul_req_t req,
	output abg_pkg::mul_rsp_t rsp
);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_RUN  = 2'd1;
	localparam logic [1:0] M_RND  = 2'd2;
	localparam logic [1:0] M_FIN  = 2'd3;

	logic [1:0]                        state_q;
	logic [abg_pkg::STEP_W-1:0]        cnt_q;
	logic                              neg_q;
	logic [1:0]                        sh_q;
	logic [abg_pkg::STATE_W-1:0]       mag_q;
	logic [abg_pkg::COEF_W-1:0]        m_q;
	logic [abg_pkg::STATE_W-1:0]       h_q;
	logic [abg_pkg::COEF_W-1:0]        l_q;
	logic                              done_q;
	abg_pkg::state_t                   res_q;

	logic [abg_pkg::PP_W-1:0]          sum;
	logic [abg_pkg::PROD_W-1:0]        prod;
	logic [abg_pkg::SHF_W-1:0]         shf;
	logic                              rbit;
	logic [abg_pkg::SHF_W:0]           rnd;
	logic [abg_pkg::STATE_W-1:0]       lim;
	logic [abg_pkg::STATE_W-1:0]       sat_mag;

	// one digit of the multiplier against the whole multiplicand magnitude
	assign sum = {{abg_pkg::DIGIT_W{1'b0}}, h_q}
		+ abg_pkg::PP_W'(mag_q) * abg_pkg::PP_W'(m_q[abg_pkg::DIGIT_W-1:0]);

	assign prod = {h_q, l_q};

	always_comb begin
		case (sh_q)
			abg_pkg::SH_HALF: begin
				shf  = abg_pkg::SHF_W'(prod >> (abg_pkg::TIME_FRAC + 1));
				rbit = prod[abg_pkg::TIME_FRAC];
			end
			abg_pkg::SH_GAIN: begin
				shf  = abg_pkg::SHF_W'(prod >> abg_pkg::GAIN_FRAC);
				rbit = prod[abg_pkg::GAIN_FRAC-1];
			end
			default: begin
				shf  = abg_pkg::SHF_W'(prod >> abg_pkg::TIME_FRAC);
				rbit = prod[abg_pkg::TIME_FRAC-1];
			end
		endcase
		// round half away from zero on the magnitude
		rnd = {1'b0, shf} + (abg_pkg::SHF_W+1)'(rbit);
		lim = neg_q ? (abg_pkg::STATE_W'(1) << (abg_pkg::STATE_W - 1))
			: ((abg_pkg::STATE_W'(1) << (abg_pkg::STATE_W - 1)) - abg_pkg::STATE_W'(1));
		if (rnd > (abg_pkg::SHF_W+1)'(lim))
			sat_mag = lim;
		else
			sat_mag = rnd[abg_pkg::STATE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						cnt_q   <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					cnt_q <= cnt_q + abg_pkg::STEP_W'(1);
					if (cnt_q == abg_pkg::STEP_W'(abg_pkg::MUL_STEPS - 1))
						state_q <= M_RND;
				end
				M_RND: state_q <= M_FIN;
				M_FIN: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.start) begin
					neg_q <= req.x[abg_pkg::STATE_W-1];
					mag_q <= req.x[abg_pkg::STATE_W-1]
						? abg_pkg::STATE_W'(0) - abg_pkg::STATE_W'(req.x)
						: abg_pkg::STATE_W'(req.x);
					m_q   <= req.m;
					sh_q  <= req.sh;
					h_q   <= '0;
					l_q   <= '0;
				end
			end
			M_RUN: begin
				// shift the low product digit out, advance the multiplier
				h_q <= sum[abg_pkg::PP_W-1:abg_pkg::DIGIT_W];
				l_q <= {sum[abg_pkg::DIGIT_W-1:0], l_q[abg_pkg::COEF_W-1:abg_pkg::DIGIT_W]};
				m_q <= m_q >> abg_pkg::DIGIT_W;
			end
			M_RND: mag_q <= sat_mag;
			M_FIN: res_q <= neg_q ? abg_pkg::state_t'(abg_pkg::STATE_W'(0) - mag_q)
				: abg_pkg::state_t'(mag_q);
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

// File: design/alpha_beta_gamma_tracking_filter_top.sv
// Top level of the alpha-beta-gamma tracking filter: sequencer, estimate registers,
// saturating adder and output register. Depends on abg_pkg and abg_serial_mul.
//
// channel  direction  handshake                       payload
// s_axis   in         s_axis_tvalid / s_axis_tready   tdata[31:0] measurement
// m_axis   out        m_axis_tvalid / m_axis_tready   tdata: position, velocity, accel
// cfg      in         cfg_we (always taken)           cfg_index, cfg_data
//
// Each item runs nine multiplications one after another through the single digit-serial
// multiplier, each made of issue, eight four-bit digit steps, rounding, sign and
// writeback; the residual is formed after the third, and the result then goes to the
// output register.
// Reset (arst_n low) restores the register defaults and zeroes all three estimates.
// A finished result waits in the output register; the next measurement is taken while
// it waits, and the sequencer holds only if the register is still full at the end.
module alpha_beta_gamma_tracking_filter_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [abg_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [31:0] measurement
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [abg_pkg::OUT_W-1:0]         m_axis_tdata,   // [31:0] position_out,
	                                                          // [63:32] velocity_out,
	                                                          // [95:64] acceleration_out
	input  logic                              cfg_we,
	input  logic [abg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [abg_pkg::COEF_W-1:0]        cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_RES   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	// multiplication steps, in order
	localparam logic [3:0] OP_VDT        = 4'd0;  // v * dt
	localparam logic [3:0] OP_ADT        = 4'd1;  // a * dt
	localparam logic [3:0] OP_ADT2       = 4'd2;  // (a * dt) * dt / 2
	localparam logic [3:0] OP_ALPHA      = 4'd3;  // alpha * r
	localparam logic [3:0] OP_BETA       = 4'd4;  // beta * r
	localparam logic [3:0] OP_BETA_INV   = 4'd5;  // (beta * r) / dt
	localparam logic [3:0] OP_GAMMA      = 4'd6;  // gamma * r
	localparam logic [3:0] OP_GAMMA_INV1 = 4'd7;  // (gamma * r) / dt
	localparam logic [3:0] OP_GAMMA_INV2 = 4'd8;  // (gamma * r) / dt^2

	localparam int SW = abg_pkg::STATE_W;
	localparam int OW = abg_pkg::SAMPLE_W;

	logic [2:0]                 state_q;
	logic [3:0]                 op_q;

	logic [abg_pkg::COEF_W-1:0] alpha_q, beta_q, gamma_q, period_q, inv_q;

	abg_pkg::state_t            pos_q, vel_q, acc_q;      // estimates
	abg_pkg::state_t            xm_q, xp_q, vp_q, adt_q, r_q, t_q;

	logic                       out_valid_q;
	logic [abg_pkg::OUT_W-1:0]  out_data_q;

	abg_pkg::mul_req_t          mul_req;
	abg_pkg::mul_rsp_t          mul_rsp;

	abg_pkg::state_t            add_a, add_b;
	logic                       add_sub;
	logic [SW:0]                add_raw;
	abg_pkg::state_t            add_res;

	logic                       cfg_clear;
	logic                       out_free;
	logic                       wb;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign wb            = (state_q == ST_WAIT) && mul_rsp.done;

	// a write to any listed register also clears the estimates
	always_comb begin
		case (cfg_index)
			abg_pkg::REG_ALPHA, abg_pkg::REG_BETA, abg_pkg::REG_GAMMA,
			abg_pkg::REG_PERIOD, abg_pkg::REG_INV_PERIOD: cfg_clear = cfg_we;
			default: cfg_clear = 1'b0;
		endcase
	end

	// operand selection for the shared multiplier
	always_comb begin
		mul_req.start = (state_q == ST_ISSUE);
		case (op_q)
			OP_VDT:   begin mul_req.x = vel_q; mul_req.m = period_q; mul_req.sh = abg_pkg::SH_TIME; end
			OP_ADT:   begin mul_req.x = acc_q; mul_req.m = period_q; mul_req.sh = abg_pkg::SH_TIME; end
			OP_ADT2:  begin mul_req.x = adt_q; mul_req.m = period_q; mul_req.sh = abg_pkg::SH_HALF; end
			OP_ALPHA: begin mul_req.x = r_q;   mul_req.m = alpha_q;  mul_req.sh = abg_pkg::SH_GAIN; end
			OP_BETA:  begin mul_req.x = r_q;   mul_req.m = beta_q;   mul_req.sh = abg_pkg::SH_GAIN; end
			OP_GAMMA: begin mul_req.x = r_q;   mul_req.m = gamma_q;  mul_req.sh = abg_pkg::SH_GAIN; end
			default:  begin mul_req.x = t_q;   mul_req.m = inv_q;    mul_req.sh = abg_pkg::SH_TIME; end
		endcase
	end

	abg_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// saturating adder, shared by the accumulating writebacks and the residual
	always_comb begin
		add_sub = 1'b0;
		add_b   = mul_rsp.res;
		case (op_q)
			OP_VDT:        add_a = pos_q;
			OP_ADT:        add_a = vel_q;
			OP_ALPHA:      add_a = xp_q;
			OP_BETA_INV:   add_a = vp_q;
			OP_GAMMA_INV2: add_a = acc_q;
			default:       add_a = xp_q;
		endcase
		if (state_q == ST_RES) begin
			add_a   = xm_q;
			add_b   = xp_q;
			add_sub = 1'b1;
		end
		add_raw = add_sub ? ({add_a[SW-1], add_a} - {add_b[SW-1], add_b})
			: ({add_a[SW-1], add_a} + {add_b[SW-1], add_b});
		if (add_raw[SW] != add_raw[SW-1])
			add_res = add_raw[SW] ? abg_pkg::state_t'({1'b1, {(SW-1){1'b0}}})
				: abg_pkg::state_t'({1'b0, {(SW-1){1'b1}}});
		else
			add_res = abg_pkg::state_t'(add_raw[SW-1:0]);
	end

	// clamp an estimate to the result width
	function automatic logic [OW-1:0] sat_out(input abg_pkg::state_t v);
		logic [SW-OW:0] top;
		top = v[SW-1:OW-1];
		if (top == '0 || top == '1)
			return v[OW-1:0];
		return v[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
	endfunction

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_VDT;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished item, or drop the one that the receiver takes
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= OP_VDT;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_rsp.done) begin
						if (op_q == OP_ADT2)
							state_q <= ST_RES;
						else if (op_q == OP_GAMMA_INV2)
							state_q <= ST_OUT;
						else begin
							op_q    <= op_q + 4'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_RES: begin
					op_q    <= OP_ALPHA;
					state_q <= ST_ISSUE;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// configuration registers and estimates; a register write wins over a writeback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= abg_pkg::COEF_W'(1) << abg_pkg::GAIN_FRAC;
			beta_q   <= '0;
			gamma_q  <= '0;
			period_q <= abg_pkg::COEF_W'(1) << abg_pkg::TIME_FRAC;
			inv_q    <= abg_pkg::COEF_W'(1) << abg_pkg::TIME_FRAC;
			pos_q    <= '0;
			vel_q    <= '0;
			acc_q    <= '0;
		end else if (cfg_clear) begin
			case (cfg_index)
				abg_pkg::REG_ALPHA:  alpha_q  <= cfg_data;
				abg_pkg::REG_BETA:   beta_q   <= cfg_data;
				abg_pkg::REG_GAMMA:  gamma_q  <= cfg_data;
				abg_pkg::REG_PERIOD: period_q <= cfg_data;
				default:             inv_q    <= cfg_data;
			endcase
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
		end else if (wb) begin
			case (op_q)
				OP_ALPHA:      pos_q <= add_res;
				OP_BETA_INV:   vel_q <= add_res;
				OP_GAMMA_INV2: acc_q <= add_res;
				default: ;
			endcase
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid)
			xm_q <= abg_pkg::state_t'(signed'(s_axis_tdata));
		if (state_q == ST_RES)
			r_q <= add_res;
		if (wb) begin
			case (op_q)
				OP_VDT:  xp_q <= add_res;
				OP_ADT: begin
					adt_q <= mul_rsp.res;
					vp_q  <= add_res;
				end
				OP_ADT2: xp_q <= add_res;
				OP_BETA, OP_GAMMA, OP_GAMMA_INV1: t_q <= mul_rsp.res;
				default: ;
			endcase
		end
		if (state_q == ST_OUT && out_free)
			out_data_q <= {sat_out(acc_q), sat_out(vel_q), sat_out(pos_q)};
	end

`ifndef SYNTHESIS
	// the multiplier only answers a step that the sequencer is waiting on
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == ST_WAIT)
		else $error("multiplier result outside wait state");

	// the step counter never runs past the last multiplication
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		op_q <= OP_GAMMA_INV2)
		else $error("step counter out of range");

	// a register write leaves all three estimates cleared
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index <= abg_pkg::REG_INV_PERIOD
		|=> pos_q == '0 && vel_q == '0 && acc_q == '0)
		else $error("estimates not cleared by register write");

	// a finished item reaches the output register once it is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not loaded into output register");
`endif

endmodule

// File: tb/tb_alpha_beta_gamma_tracking_filter_top.sv
// Self-checking testbench for alpha_beta_gamma_tracking_filter_top: directed and random
// measurements against a cycle-free predictor of the Q16.16 filter step.
// Depends on abg_pkg and the filter RTL only.
`timescale 1ns / 100ps

module tb_alpha_beta_gamma_tracking_filter_top;

	// indexes outside the register map
	localparam logic [abg_pkg::CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 3'd5;
	localparam logic [abg_pkg::CFG_IDX_W-1:0] REG_LAST_INDEX     = 3'd7;

	localparam logic [abg_pkg::COEF_W-1:0] GAIN_ONE = 32'h4000_0000;  // 1.0 in Q2.30
	localparam logic [abg_pkg::COEF_W-1:0] TIME_ONE = 32'h0001_0000;  // 1.0 in Q16.16
	localparam logic [abg_pkg::COEF_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	localparam longint ST_MAX  = (longint'(1) << (abg_pkg::STATE_W - 1)) - 1;
	localparam longint ST_MIN  = -ST_MAX - 1;
	localparam longint SMP_MAX = (longint'(1) << (abg_pkg::SAMPLE_W - 1)) - 1;
	localparam longint SMP_MIN = -SMP_MAX - 1;

	localparam int BLOCK_ITEMS = 50;

	// one result transaction, fields kept apart for the comparison
	typedef struct packed {
		logic [abg_pkg::SAMPLE_W-1:0] acceleration;
		logic [abg_pkg::SAMPLE_W-1:0] velocity;
		logic [abg_pkg::SAMPLE_W-1:0] position;
	} estimate_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [abg_pkg::SAMPLE_W-1:0]  s_axis_tdata = '0;  // [31:0] measurement
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [abg_pkg::OUT_W-1:0]     m_axis_tdata;       // [31:0] position, [63:32] velocity,
	                                                   // [95:64] acceleration
	logic                          cfg_we = 1'b0;
	logic [abg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [abg_pkg::COEF_W-1:0]    cfg_data = '0;

	// filter settings and estimates as the predictor sees them
	logic [abg_pkg::COEF_W-1:0] gain_alpha, gain_beta, gain_gamma, period_dt, period_inv;
	longint                     est_pos, est_vel, est_acc;

	// synthetic target path for well-formed measurement runs
	longint path_pos, path_vel, path_acc;

	estimate_t pending_estimates[$];
	int        mismatch_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	alpha_beta_gamma_tracking_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (about 600 transactions, plus sender
	// gaps and receiver stalls).
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint clamp_state(input longint v);
		if (v > ST_MAX) return ST_MAX;
		if (v < ST_MIN) return ST_MIN;
		return v;
	endfunction

	// (x * m) >> sh with the magnitude rounded half away from zero, saturated to state
	function automatic longint scaled_product(input longint x,
	                                          input logic [abg_pkg::COEF_W-1:0] m,
	                                          input int sh);
		logic [127:0] mag;
		logic [127:0] q;
		logic [127:0] lim;
		bit           neg;
		neg = (x < 0);
		mag = neg ? 128'(-x) : 128'(x);
		q   = ((mag * 128'(m)) + (128'd1 << (sh - 1))) >> sh;
		lim = neg ? 128'(ST_MAX) + 128'd1 : 128'(ST_MAX);
		if (q > lim) return neg ? ST_MIN : ST_MAX;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic logic [abg_pkg::SAMPLE_W-1:0] to_sample(input longint v);
		if (v > SMP_MAX) return SMP_MAX[abg_pkg::SAMPLE_W-1:0];
		if (v < SMP_MIN) return SMP_MIN[abg_pkg::SAMPLE_W-1:0];
		return v[abg_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic void clear_estimates();
		est_pos = 0;
		est_vel = 0;
		est_acc = 0;
	endfunction

	// Advance the estimates by one measurement and return the new outputs.
	function automatic estimate_t track_step(input logic [abg_pkg::SAMPLE_W-1:0] meas);
		longint    meas_pos, vdt, adt, adt2h, pos_pred, vel_pred, resid, corr;
		estimate_t res;
		meas_pos = clamp_state(longint'($signed(meas)));
		vdt      = scaled_product(est_vel, period_dt, abg_pkg::TIME_FRAC);
		adt      = scaled_product(est_acc, period_dt, abg_pkg::TIME_FRAC);
		adt2h    = scaled_product(adt, period_dt, abg_pkg::TIME_FRAC + 1);
		pos_pred = clamp_state(clamp_state(est_pos + vdt) + adt2h);
		vel_pred = clamp_state(est_vel + adt);
		resid    = clamp_state(meas_pos - pos_pred);

		est_pos = clamp_state(pos_pred
			+ scaled_product(resid, gain_alpha, abg_pkg::GAIN_FRAC));
		corr    = scaled_product(resid, gain_beta, abg_pkg::GAIN_FRAC);
		est_vel = clamp_state(vel_pred
			+ scaled_product(corr, period_inv, abg_pkg::TIME_FRAC));
		corr    = scaled_product(resid, gain_gamma, abg_pkg::GAIN_FRAC);
		corr    = scaled_product(corr, period_inv, abg_pkg::TIME_FRAC);
		est_acc = clamp_state(est_acc
			+ scaled_product(corr, period_inv, abg_pkg::TIME_FRAC));

		res.position     = to_sample(est_pos);
		res.velocity     = to_sample(est_vel);
		res.acceleration = to_sample(est_acc);
		return res;
	endfunction

	// ---------------------------------------------------------------- checker

	// Compare every result transaction with the oldest pending estimate.
	always @(posedge clk) begin
		estimate_t got;
		estimate_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_estimates.pop_front();
				if (got.position !== want.position) begin
					$display("%0t: position expected %h got %h", $time,
					         want.position, got.position);
					mismatch_count++;
				end
				if (got.velocity !== want.velocity) begin
					$display("%0t: velocity expected %h got %h", $time,
					         want.velocity, got.velocity);
					mismatch_count++;
				end
				if (got.acceleration !== want.acceleration) begin
					$display("%0t: acceleration expected %h got %h", $time,
					         want.acceleration, got.acceleration);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: drop tready at random in recv_idle_pct of the cycles.
	always @(negedge clk) begin
		m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
	end

	// ---------------------------------------------------------------- drivers

	// Present one measurement and hold it until the transaction completes.
	// tvalid is left high so back-to-back sends never toggle it within a step.
	task automatic send_measurement(input logic [abg_pkg::SAMPLE_W-1:0] meas);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = meas;
		do @(posedge clk); while (!s_axis_tready);
		pending_estimates.push_back(track_step(meas));
	endtask

	// Stop sending and hold until every pending result has been taken.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	// Write one register; only called once the filter is idle.
	task automatic write_register(input logic [abg_pkg::CFG_IDX_W-1:0] idx,
	                              input logic [abg_pkg::COEF_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			abg_pkg::REG_ALPHA:      gain_alpha = value;
			abg_pkg::REG_BETA:       gain_beta  = value;
			abg_pkg::REG_GAMMA:      gain_gamma = value;
			abg_pkg::REG_PERIOD:     period_dt  = value;
			abg_pkg::REG_INV_PERIOD: period_inv = value;
			default:                 return;  // unmapped: estimates kept
		endcase
		clear_estimates();
	endtask

	task automatic program_settings(input logic [abg_pkg::COEF_W-1:0] alpha,
	                                input logic [abg_pkg::COEF_W-1:0] beta,
	                                input logic [abg_pkg::COEF_W-1:0] gamma,
	                                input logic [abg_pkg::COEF_W-1:0] dt,
	                                input logic [abg_pkg::COEF_W-1:0] inv_dt);
		drain_results();
		write_register(abg_pkg::REG_ALPHA, alpha);
		write_register(abg_pkg::REG_BETA, beta);
		write_register(abg_pkg::REG_GAMMA, gamma);
		write_register(abg_pkg::REG_PERIOD, dt);
		write_register(abg_pkg::REG_INV_PERIOD, inv_dt);
	endtask

	function automatic logic [abg_pkg::COEF_W-1:0] pick_extreme();
		case ($urandom_range(3))
			0:       return '0;
			1:       return ALL_ONES;
			2:       return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	// Start a fresh target path: modest speed and acceleration in Q16.16.
	function automatic void restart_path();
		path_pos = longint'($signed(32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000));
		path_vel = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
		path_acc = longint'($urandom_range(0, 1 << 13)) - (1 << 12);
	endfunction

	// Next measurement: mostly path plus small noise, some outliers and raw words.
	function automatic logic [abg_pkg::SAMPLE_W-1:0] next_measurement();
		int pick;
		pick = $urandom_range(99);
		if (pick < 12) return $urandom;
		if (pick < 14) begin
			return (pick == 12) ? SMP_MAX[abg_pkg::SAMPLE_W-1:0]
				: SMP_MIN[abg_pkg::SAMPLE_W-1:0];
		end
		path_vel = path_vel + path_acc;
		path_pos = path_pos + path_vel;
		if (path_pos > SMP_MAX || path_pos < SMP_MIN) restart_path();
		if (pick < 20) return to_sample(path_pos + longint'($signed($urandom)) / 4);
		return to_sample(path_pos + longint'($urandom_range(0, 1 << 12)) - (1 << 11));
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset defaults: alpha 1, other gains 0, so the position follows the input.
	task automatic test_reset_defaults();
		send_measurement('0);
		send_measurement(SMP_MAX[abg_pkg::SAMPLE_W-1:0]);
		send_measurement(SMP_MIN[abg_pkg::SAMPLE_W-1:0]);
		send_measurement(ALL_ONES);
		send_measurement(32'd1);
	endtask

	// Largest gains and periods drive every term into saturation; zero gains then
	// leave the estimates at the prediction.
	task automatic test_gain_extremes();
		program_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		send_measurement(SMP_MAX[abg_pkg::SAMPLE_W-1:0]);
		send_measurement(SMP_MIN[abg_pkg::SAMPLE_W-1:0]);
		send_measurement(SMP_MAX[abg_pkg::SAMPLE_W-1:0]);
		send_measurement(32'd1);
		program_settings('0, '0, '0, TIME_ONE, TIME_ONE);
		send_measurement(32'h1234_5678);
		send_measurement(32'h8765_4321);
	endtask

	// A zero period, and separately a zero reciprocal, removes the terms they scale.
	task automatic test_zero_period();
		program_settings(GAIN_ONE >> 1, GAIN_ONE >> 2, GAIN_ONE >> 3, '0, TIME_ONE);
		send_measurement(32'h0010_0000);
		send_measurement(32'h0030_0000);
		send_measurement(32'hFFE0_0000);
		program_settings(GAIN_ONE >> 1, GAIN_ONE >> 2, GAIN_ONE >> 3, TIME_ONE, '0);
		send_measurement(32'h0010_0000);
		send_measurement(32'h0030_0000);
		send_measurement(32'hFFE0_0000);
	endtask

	// Writes to the unmapped indexes must leave settings and estimates untouched.
	task automatic test_unmapped_index();
		logic [abg_pkg::CFG_IDX_W-1:0] idx;
		program_settings(GAIN_ONE >> 1, GAIN_ONE >> 2, GAIN_ONE >> 4, TIME_ONE, TIME_ONE);
		send_measurement(32'h0002_0000);
		send_measurement(32'h0005_0000);
		drain_results();
		for (idx = REG_FIRST_UNMAPPED; ; idx++) begin
			write_register(idx, $urandom);
			if (idx == REG_LAST_INDEX) break;
		end
		send_measurement(32'h0009_0000);
		send_measurement(32'h000E_0000);
	endtask

	// Random blocks, each under new settings, with the given idle shares.
	// One block per call pauses the sender until every result is back.
	task automatic test_random_tracking(input int send_pct, input int recv_pct,
	                                    input int blocks);
		logic [abg_pkg::COEF_W-1:0] dt;
		int                         held_block;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		held_block    = $urandom_range(blocks - 1);
		for (int b = 0; b < blocks; b++) begin
			if ($urandom_range(4) == 0) begin
				program_settings(pick_extreme(), pick_extreme(), pick_extreme(),
				                 pick_extreme(), pick_extreme());
			end else begin
				dt = $urandom_range(1 << 12, 1 << 18);
				program_settings($urandom_range(0, GAIN_ONE), $urandom_range(0, GAIN_ONE >> 1),
				                 $urandom_range(0, GAIN_ONE >> 3), dt,
				                 32'((64'd1 << 32) / dt));
			end
			if ($urandom_range(3) == 0) begin
				write_register(3'($urandom_range(REG_FIRST_UNMAPPED, REG_LAST_INDEX)),
				               $urandom);
			end
			restart_path();
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				if (b == held_block && i == BLOCK_ITEMS / 2) drain_results();
				send_measurement(next_measurement());
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		gain_alpha = GAIN_ONE;
		gain_beta  = '0;
		gain_gamma = '0;
		period_dt  = TIME_ONE;
		period_inv = TIME_ONE;
		clear_estimates();

		// hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_gain_extremes();
		test_zero_period();
		test_unmapped_index();

		test_random_tracking(32, 70, 4);
		test_random_tracking(70, 32, 4);
		test_random_tracking(0, 0, 3);

		// let the last results out, then wait for any stray result
		drain_results();
		repeat (120) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
design/abg_pkg.sv
design/abg_serial_mul.sv
design/alpha_beta_gamma_tracking_filter_top.sv
tb/tb_alpha_beta_gamma_tracking_filter_top.sv
